[rtl/core/max_motion_window_finder_top_assert.svh]
// ---------------------------------------------------------------------------
// max motion window finder assertion macros
// shared property wrappers, clocked on clk_i, disabled while rst_ni is low
// ---------------------------------------------------------------------------
`ifndef MAX_MOTION_WINDOW_FINDER_TOP_ASSERT_SVH
`define MAX_MOTION_WINDOW_FINDER_TOP_ASSERT_SVH

// same-cycle implication
`define MMWF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MMWF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/mmwf_pkg.sv]
// ---------------------------------------------------------------------------
// mmwf_pkg
// shared types, register indexes and constants of the max motion window finder
// ---------------------------------------------------------------------------
package mmwf_pkg;

  // default sizes
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int MAX_WIN_H_DEF  = 64;

  // configuration port
  localparam int CFG_DW   = 40;
  localparam int NUM_REGS = 7;
  localparam logic [2:0] REG_FRAME_W  = 3'd0;
  localparam logic [2:0] REG_FRAME_H  = 3'd1;
  localparam logic [2:0] REG_WIN_W    = 3'd2;
  localparam logic [2:0] REG_WIN_H    = 3'd3;
  localparam logic [2:0] REG_SCALE_XY = 3'd4;
  localparam logic [2:0] REG_SCALE_Z  = 3'd5;
  localparam logic [2:0] REG_THRESH   = 3'd6;

  // register reset values
  localparam logic [8:0]  FRAME_W_RST  = 9'd160;
  localparam logic [8:0]  FRAME_H_RST  = 9'd120;
  localparam logic [8:0]  WIN_W_RST    = 9'd60;
  localparam logic [6:0]  WIN_H_RST    = 7'd45;
  localparam logic [19:0] SCALE_XY_RST = 20'd7989;
  localparam logic [15:0] SCALE_Z_RST  = 16'd1024;
  localparam logic [39:0] THRESH_RST   = 40'd10000000;

  // magnitude arithmetic
  localparam logic [15:0] DEPTH_UNKNOWN_MM = 16'd1000;
  localparam logic [9:0]  UM_PER_MM        = 10'd1000;
  localparam logic [19:0] UM_PER_M         = 20'd1000000;
  localparam logic [24:0] TERM_MAX         = 25'h1000000;
  localparam logic [23:0] MAG_MAX          = 24'hFFFFFF;
  localparam int          SQ_W             = 52;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_A,
    S_MUL_B,
    S_TERM,
    S_SQUARE,
    S_SUM,
    S_ROOT,
    S_READ,
    S_COL,
    S_ROW,
    S_BEST,
    S_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic mul_a;
    logic mul_b;
    logic term;
    logic square;
    logic sum;
    logic root_step;
    logic mem_read;
    logic col_upd;
    logic row_upd;
    logic best_upd;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic root_done;
    logic frame_end;
    logic out_busy;
  } status_t;

endpackage

[rtl/core/mmwf_sqrt.sv]
// ---------------------------------------------------------------------------
// mmwf_sqrt
// bit-serial square root, two radicand bits per cycle, rounded and saturated
// ---------------------------------------------------------------------------
module mmwf_sqrt
  import mmwf_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            step_i,
  input  logic [SQ_W-1:0] radicand_i,
  output logic            done_o,
  output logic [23:0]     mag_o
);

  localparam logic [SQ_W-1:0] TOP_BIT = SQ_W'(1) << (SQ_W - 2);

  logic [SQ_W-1:0] rem_q, root_q, bit_q;
  logic [SQ_W-1:0] trial, rnd;

  assign trial  = root_q + bit_q;
  assign done_o = (bit_q == '0);

  // round to nearest, half down, then saturate
  assign rnd   = (rem_q > root_q) ? root_q + SQ_W'(1) : root_q;
  assign mag_o = (rnd > SQ_W'(MAG_MAX)) ? MAG_MAX : rnd[23:0];

  // bit pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= '0;
    end else if (start_i) begin
      bit_q <= TOP_BIT;
    end else if (step_i && !done_o) begin
      bit_q <= bit_q >> 2;
    end
  end

  // remainder and partial root
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= radicand_i;
      root_q <= '0;
    end else if (step_i && !done_o) begin
      if (rem_q >= trial) begin
        rem_q  <= rem_q - trial;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
    end
  end

endmodule

[rtl/core/mmwf_datapath.sv]
// ---------------------------------------------------------------------------
// mmwf_datapath
// magnitude arithmetic, line and column-sum memories, window tracking, result
// ---------------------------------------------------------------------------
`include "max_motion_window_finder_top_assert.svh"

module mmwf_datapath
  import mmwf_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int MAX_WIN_H  = MAX_WIN_H_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  cmd_t                               cmd_i,
  output status_t                            status_o,
  input  logic                               cfg_restart_i,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]     fw_i,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]    fh_i,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]     ww_i,
  input  logic [$clog2(MAX_WIN_H+1)-1:0]     wh_i,
  input  logic [19:0]                        scale_xy_i,
  input  logic [15:0]                        scale_z_i,
  input  logic [39:0]                        threshold_i,
  input  logic signed [15:0]                 flow_x_i,
  input  logic signed [15:0]                 flow_y_i,
  input  logic signed [15:0]                 flow_z_i,
  input  logic [15:0]                        depth_mm_i,
  input  logic                               out_stall_i,
  output logic                               out_valid_o,
  output logic [7:0]                         best_x_o,
  output logic [7:0]                         best_y_o,
  output logic [39:0]                        best_sum_o,
  output logic                               kept_previous_o
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int LW    = $clog2(MAX_WIN_H);
  localparam int DEPTH = MAX_WIN_H * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);

  function automatic logic [24:0] clamp_term(logic [63:0] v);
    return (v > 64'(TERM_MAX)) ? TERM_MAX : v[24:0];
  endfunction

  // pixel and arithmetic registers
  logic signed [15:0] fx_q, fy_q, fz_q;
  logic [15:0]        d_q;
  logic [15:0]        ax, ay, az, dd;
  logic [35:0]        pxs_q, pys_q;
  logic [25:0]        dk_q;
  logic [31:0]        pz_q;
  logic [43:0]        xlo_q, xhi_q, ylo_q, yhi_q;
  logic [51:0]        pzm_q;
  logic [63:0]        xs, ys, zs;
  logic [24:0]        tx_q, ty_q, tz_q;
  logic [49:0]        sqx_q, sqy_q, sqz_q;
  logic [SQ_W-1:0]    radicand;
  logic               root_done;
  logic [23:0]        root_mag;

  // memories and window state
  logic [23:0]   line_mem [DEPTH];
  logic [29:0]   col_mem  [MAX_WIDTH];
  logic [23:0]   mag_q, old_q;
  logic [29:0]   cs_q, csw_q, csn_q, cs_d;
  logic [CW-1:0] col_q, csw_idx;
  logic [RW-1:0] row_q;
  logic [LW-1:0] lr_q;
  logic [AW-1:0] line_addr;
  logic [39:0]   rws_q, rws_d, best_q;
  logic [7:0]    bx_q, by_q, prev_x_q, prev_y_q;
  logic          seen_q, prev_v_q, out_valid_q, out_valid_d;
  logic          first_row, past_win, col_ge_ww, win_fits, take_best;
  logic          row_last, frame_end, above, frame_clear;
  logic [7:0]    corner_x, corner_y, res_x, res_y;
  logic          res_kept;

  // absolute flow and depth substitute
  assign ax = fx_q[15] ? 16'(-fx_q) : 16'(fx_q);
  assign ay = fy_q[15] ? 16'(-fy_q) : 16'(fy_q);
  assign az = fz_q[15] ? 16'(-fz_q) : 16'(fz_q);
  assign dd = (d_q == '0) ? DEPTH_UNKNOWN_MM : d_q;

  // term rounding: reassemble split products, round, shift, clamp
  assign xs = ((64'(xhi_q) << 18) + 64'(xlo_q) + (64'd1 << 27)) >> 28;
  assign ys = ((64'(yhi_q) << 18) + 64'(ylo_q) + (64'd1 << 27)) >> 28;
  assign zs = (64'(pzm_q) + (64'd1 << 15)) >> 16;

  assign radicand = SQ_W'(sqx_q) + SQ_W'(sqy_q) + SQ_W'(sqz_q);

  // magnitude pipeline registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      fx_q <= flow_x_i;
      fy_q <= flow_y_i;
      fz_q <= flow_z_i;
      d_q  <= depth_mm_i;
    end
    if (cmd_i.mul_a) begin
      pxs_q <= 36'(ax) * 36'(scale_xy_i);
      pys_q <= 36'(ay) * 36'(scale_xy_i);
      dk_q  <= 26'(dd) * 26'(UM_PER_MM);
      pz_q  <= 32'(az) * 32'(scale_z_i);
    end
    if (cmd_i.mul_b) begin
      xlo_q <= 44'(pxs_q[17:0]) * 44'(dk_q);
      xhi_q <= 44'(pxs_q[35:18]) * 44'(dk_q);
      ylo_q <= 44'(pys_q[17:0]) * 44'(dk_q);
      yhi_q <= 44'(pys_q[35:18]) * 44'(dk_q);
      pzm_q <= 52'(pz_q) * 52'(UM_PER_M);
    end
    if (cmd_i.term) begin
      tx_q <= clamp_term(xs);
      ty_q <= clamp_term(ys);
      tz_q <= clamp_term(zs);
    end
    if (cmd_i.square) begin
      sqx_q <= 50'(tx_q) * 50'(tx_q);
      sqy_q <= 50'(ty_q) * 50'(ty_q);
      sqz_q <= 50'(tz_q) * 50'(tz_q);
    end
  end

  mmwf_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.sum),
    .step_i     (cmd_i.root_step),
    .radicand_i (radicand),
    .done_o     (root_done),
    .mag_o      (root_mag)
  );

  // window bookkeeping
  assign first_row = (row_q == '0);
  assign past_win  = 32'(row_q) >= 32'(wh_i);
  assign col_ge_ww = 32'(col_q) >= 32'(ww_i);
  assign csw_idx   = CW'(32'(col_q) - 32'(ww_i));
  assign line_addr = AW'(32'(lr_q) * MAX_WIDTH + 32'(col_q));
  assign cs_d      = (first_row ? 30'd0 : cs_q) + 30'(mag_q)
                   - (past_win ? 30'(old_q) : 30'd0);
  assign rws_d     = ((col_q == '0) ? 40'd0 : rws_q) + 40'(csn_q)
                   - (col_ge_ww ? 40'(csw_q) : 40'd0);
  assign win_fits  = (32'(row_q) + 1 >= 32'(wh_i)) && (32'(col_q) + 1 >= 32'(ww_i));
  assign take_best = win_fits && (!seen_q || rws_q > best_q);
  assign corner_x  = 8'(32'(col_q) + 1 - 32'(ww_i));
  assign corner_y  = 8'(32'(row_q) + 1 - 32'(wh_i));
  assign row_last  = 32'(col_q) + 1 >= 32'(fw_i);
  assign frame_end = row_last && (32'(row_q) + 1 >= 32'(fh_i));

  // frame-end choice: best window, else previous corner, else best or origin
  assign above = seen_q && (best_q >= threshold_i);
  always_comb begin
    res_kept = 1'b0;
    if (above) begin
      res_x = bx_q;
      res_y = by_q;
    end else if (prev_v_q) begin
      res_x    = prev_x_q;
      res_y    = prev_y_q;
      res_kept = 1'b1;
    end else if (seen_q) begin
      res_x = bx_q;
      res_y = by_q;
    end else begin
      res_x = '0;
      res_y = '0;
    end
  end

  // result valid: cleared when the beat leaves, set on a load with no restart
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.emit && !cfg_restart_i) begin
      out_valid_d = 1'b1;
    end
  end

  // memory reads, registered
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_read) begin
      mag_q <= root_mag;
      old_q <= line_mem[line_addr];
      cs_q  <= col_mem[col_q];
      csw_q <= col_mem[csw_idx];
    end
  end

  // memory writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.col_upd) begin
      line_mem[line_addr] <= mag_q;
      col_mem[col_q]      <= cs_d;
      csn_q               <= cs_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      best_x_o        <= res_x;
      best_y_o        <= res_y;
      best_sum_o      <= seen_q ? best_q : 40'd0;
      kept_previous_o <= res_kept;
    end
  end

  // position, running sum, best window and previous corner
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      lr_q        <= '0;
      rws_q       <= '0;
      best_q      <= '0;
      bx_q        <= '0;
      by_q        <= '0;
      seen_q      <= 1'b0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      prev_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_restart_i) begin
        col_q  <= '0;
        row_q  <= '0;
        lr_q   <= '0;
        rws_q  <= '0;
        best_q <= '0;
        bx_q   <= '0;
        by_q   <= '0;
        seen_q <= 1'b0;
      end else if (cmd_i.row_upd) begin
        rws_q <= rws_d;
      end else if (cmd_i.best_upd) begin
        if (take_best) begin
          best_q <= rws_q;
          bx_q   <= corner_x;
          by_q   <= corner_y;
          seen_q <= 1'b1;
        end
        if (!frame_end) begin
          if (row_last) begin
            col_q <= '0;
            row_q <= row_q + RW'(1);
            lr_q  <= (32'(lr_q) + 1 >= 32'(wh_i)) ? '0 : lr_q + LW'(1);
          end else begin
            col_q <= col_q + CW'(1);
          end
        end
      end else if (cmd_i.emit) begin
        if (seen_q || prev_v_q) begin
          prev_x_q <= res_x;
          prev_y_q <= res_y;
          prev_v_q <= 1'b1;
        end
        col_q  <= '0;
        row_q  <= '0;
        lr_q   <= '0;
        rws_q  <= '0;
        best_q <= '0;
        bx_q   <= '0;
        by_q   <= '0;
        seen_q <= 1'b0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o.root_done = root_done;
  assign status_o.frame_end = frame_end;
  assign status_o.out_busy  = out_valid_q && out_stall_i;

  // frame position and best window back at their start values
  assign frame_clear = (col_q == '0) && (row_q == '0) && !seen_q;

  `MMWF_ASSERT_NOW(a_root_ready, cmd_i.mem_read, root_done, "magnitude before root done")
  `MMWF_ASSERT_NEXT(a_emit_restart, cmd_i.emit, out_valid_q && frame_clear, "no restart")
  `MMWF_ASSERT_NOW(a_line_in_window, 1'b1, 32'(lr_q) < 32'(wh_i), "line slot too high")

endmodule

[rtl/core/mmwf_ctrl.sv]
// ---------------------------------------------------------------------------
// mmwf_ctrl
// per-pixel sequencer: arithmetic steps, root iterations, memory and result
// ---------------------------------------------------------------------------
module mmwf_ctrl
  import mmwf_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MUL_A;
        end
      end
      S_MUL_A: begin
        cmd_o.mul_a = 1'b1;
        state_d     = S_MUL_B;
      end
      S_MUL_B: begin
        cmd_o.mul_b = 1'b1;
        state_d     = S_TERM;
      end
      S_TERM: begin
        cmd_o.term = 1'b1;
        state_d    = S_SQUARE;
      end
      S_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_ROOT;
      end
      S_ROOT: begin
        if (status_i.root_done) begin
          state_d = S_READ;
        end else begin
          cmd_o.root_step = 1'b1;
        end
      end
      S_READ: begin
        cmd_o.mem_read = 1'b1;
        state_d        = S_COL;
      end
      S_COL: begin
        cmd_o.col_upd = 1'b1;
        state_d       = S_ROW;
      end
      S_ROW: begin
        cmd_o.row_upd = 1'b1;
        state_d       = S_BEST;
      end
      S_BEST: begin
        cmd_o.best_upd = 1'b1;
        state_d        = status_i.frame_end ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (!status_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

[rtl/core/max_motion_window_finder_top.sv]
// ---------------------------------------------------------------------------
// max_motion_window_finder_top
// finds the window with the largest scene-flow motion sum in each frame
// ---------------------------------------------------------------------------
// Each pixel beat runs the steps multiply, second multiply, term, square,
// sum, the bit-serial square root (one root bit per cycle), memory read and
// column, row and best-window updates before the next pixel is accepted.
// The last pixel of a frame adds an emit step, held while the previous
// result beat is stalled, to load the result register. Configuration
// writes restart the frame in progress and keep the previous corner.
module max_motion_window_finder_top
  import mmwf_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int MAX_WIN_H  = MAX_WIN_H_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [CFG_DW-1:0]  cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] flow_x_i,
  input  logic signed [15:0] flow_y_i,
  input  logic signed [15:0] flow_z_i,
  input  logic [15:0]        depth_mm_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         best_x_o,
  output logic [7:0]         best_y_o,
  output logic [39:0]        best_sum_o,
  output logic               kept_previous_o
);

  localparam int FW  = $clog2(MAX_WIDTH + 1);
  localparam int FHW = $clog2(MAX_HEIGHT + 1);
  localparam int WHW = $clog2(MAX_WIN_H + 1);

  function automatic int clamp_dim(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  logic [8:0]   frame_w_q, frame_h_q, win_w_q;
  logic [6:0]   win_h_q;
  logic [19:0]  scale_xy_q;
  logic [15:0]  scale_z_q;
  logic [39:0]  thresh_q;
  logic [FW-1:0]  fw, ww;
  logic [FHW-1:0] fh;
  logic [WHW-1:0] wh;
  logic           cfg_restart;
  cmd_t           cmd;
  status_t        status;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_w_q  <= FRAME_W_RST;
      frame_h_q  <= FRAME_H_RST;
      win_w_q    <= WIN_W_RST;
      win_h_q    <= WIN_H_RST;
      scale_xy_q <= SCALE_XY_RST;
      scale_z_q  <= SCALE_Z_RST;
      thresh_q   <= THRESH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FRAME_W:  frame_w_q  <= cfg_data_i[8:0];
        REG_FRAME_H:  frame_h_q  <= cfg_data_i[8:0];
        REG_WIN_W:    win_w_q    <= cfg_data_i[8:0];
        REG_WIN_H:    win_h_q    <= cfg_data_i[6:0];
        REG_SCALE_XY: scale_xy_q <= cfg_data_i[19:0];
        REG_SCALE_Z:  scale_z_q  <= cfg_data_i[15:0];
        REG_THRESH:   thresh_q   <= cfg_data_i[39:0];
        default: ;
      endcase
    end
  end

  assign cfg_restart = cfg_we_i && (32'(cfg_index_i) < NUM_REGS);

  // clamped geometry
  assign fw = FW'(clamp_dim(int'(frame_w_q), MAX_WIDTH));
  assign fh = FHW'(clamp_dim(int'(frame_h_q), MAX_HEIGHT));
  assign ww = FW'(clamp_dim(int'(win_w_q), MAX_WIDTH));
  assign wh = WHW'(clamp_dim(int'(win_h_q), MAX_WIN_H));

  mmwf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mmwf_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_WIN_H  (MAX_WIN_H)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_restart_i   (cfg_restart),
    .fw_i            (fw),
    .fh_i            (fh),
    .ww_i            (ww),
    .wh_i            (wh),
    .scale_xy_i      (scale_xy_q),
    .scale_z_i       (scale_z_q),
    .threshold_i     (thresh_q),
    .flow_x_i        (flow_x_i),
    .flow_y_i        (flow_y_i),
    .flow_z_i        (flow_z_i),
    .depth_mm_i      (depth_mm_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .best_x_o        (best_x_o),
    .best_y_o        (best_y_o),
    .best_sum_o      (best_sum_o),
    .kept_previous_o (kept_previous_o)
  );

endmodule

[tb/mmwf_checker.sv]
// ---------------------------------------------------------------------------
// mmwf_checker
// watches the pixel, result and configuration ports of the window finder,
// predicts each frame-end corner and compares it with the result beats
// ---------------------------------------------------------------------------
module mmwf_checker
  import mmwf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [CFG_DW-1:0]  cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [15:0]        flow_x_i,
  input  logic [15:0]        flow_y_i,
  input  logic [15:0]        flow_z_i,
  input  logic [15:0]        depth_mm_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [7:0]         best_x_i,
  input  logic [7:0]         best_y_i,
  input  logic [39:0]        best_sum_i,
  input  logic               kept_previous_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 frames_done_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_W = MAX_WIDTH_DEF;
  localparam int FRAME_H_MAX = MAX_HEIGHT_DEF;
  localparam int WIN_H_MAX = MAX_WIN_H_DEF;

  typedef struct {
    logic [7:0]  x;
    logic [7:0]  y;
    logic [39:0] sum;
    logic        kept;
  } corner_t;

  corner_t corner_q[$];

  // register copies
  logic [8:0]  frame_w_q, frame_h_q, win_w_q;
  logic [6:0]  win_h_q;
  logic [19:0] scale_xy_q;
  logic [15:0] scale_z_q;
  logic [39:0] thresh_q;

  // window search state
  logic [23:0] mag_lines [WIN_H_MAX*LINE_W];
  logic [29:0] col_sum [LINE_W];
  logic [39:0] win_sum, top_sum;
  int          col_pos, row_pos;
  logic [7:0]  top_x, top_y, prev_x, prev_y;
  logic        have_window, have_prev;

  function automatic int clamp_size(logic [8:0] v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  function automatic logic [63:0] abs_q88(logic [15:0] v);
    return v[15] ? (64'h10000 - {48'b0, v}) : {48'b0, v};
  endfunction

  // motion magnitude in micrometres, rounded root of the three squared terms
  function automatic logic [23:0] motion_um(logic [15:0] fx, logic [15:0] fy,
                                            logic [15:0] fz, logic [15:0] dmm);
    logic [63:0] dd, tx, ty, tz, s, root, cand;
    dd = (dmm == 0) ? 64'd1000 : {48'b0, dmm};
    tx = (abs_q88(fx) * scale_xy_q * dd * 64'd1000 + (64'd1 << 27)) >> 28;
    ty = (abs_q88(fy) * scale_xy_q * dd * 64'd1000 + (64'd1 << 27)) >> 28;
    tz = (abs_q88(fz) * scale_z_q * 64'd1000000 + (64'd1 << 15)) >> 16;
    if (tx > (64'd1 << 24)) tx = 64'd1 << 24;
    if (ty > (64'd1 << 24)) ty = 64'd1 << 24;
    if (tz > (64'd1 << 24)) tz = 64'd1 << 24;
    s = tx * tx + ty * ty + tz * tz;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (cand * cand <= s) root = cand;
    end
    if (s - root * root > root) root++;
    if (root > 64'hFFFFFF) root = 64'hFFFFFF;
    return root[23:0];
  endfunction

  function automatic void clear_frame();
    foreach (col_sum[i]) col_sum[i] = '0;
    win_sum = '0;
    col_pos = 0;
    row_pos = 0;
    top_sum = '0;
    top_x = '0;
    top_y = '0;
    have_window = 1'b0;
  endfunction

  function automatic void write_reg(logic [2:0] idx, logic [39:0] v);
    case (idx)
      REG_FRAME_W:  frame_w_q = v[8:0];
      REG_FRAME_H:  frame_h_q = v[8:0];
      REG_WIN_W:    win_w_q = v[8:0];
      REG_WIN_H:    win_h_q = v[6:0];
      REG_SCALE_XY: scale_xy_q = v[19:0];
      REG_SCALE_Z:  scale_z_q = v[15:0];
      REG_THRESH:   thresh_q = v;
      default: return;
    endcase
    clear_frame();
  endfunction

  // one pixel beat; pushes the corner when the frame closes
  function automatic void take_pixel(logic [15:0] fx, logic [15:0] fy,
                                     logic [15:0] fz, logic [15:0] dmm);
    int fw, fh, ww, wh, c, r, slot;
    logic [23:0] mag, old;
    logic [31:0] cs;
    corner_t res;
    fw = clamp_size(frame_w_q, LINE_W);
    fh = clamp_size(frame_h_q, FRAME_H_MAX);
    ww = clamp_size(win_w_q, LINE_W);
    wh = clamp_size({2'b0, win_h_q}, WIN_H_MAX);
    c = (col_pos >= fw) ? 0 : col_pos;
    r = (row_pos >= fh) ? 0 : row_pos;
    mag = motion_um(fx, fy, fz, dmm);
    slot = (r % wh) * LINE_W + c;
    old = mag_lines[slot];
    mag_lines[slot] = mag;
    cs = {2'b0, col_sum[c]} + mag;
    if (r >= wh) cs = cs - old;
    col_sum[c] = cs[29:0];
    if (c == 0) win_sum = '0;
    win_sum = win_sum + col_sum[c];
    if (c >= ww) win_sum = win_sum - col_sum[c - ww];
    // earliest maximum wins
    if (r + 1 >= wh && c + 1 >= ww) begin
      if (!have_window || win_sum > top_sum) begin
        top_sum = win_sum;
        top_x = 8'(c + 1 - ww);
        top_y = 8'(r + 1 - wh);
        have_window = 1'b1;
      end
    end
    c++;
    if (c < fw) begin
      col_pos = c;
      row_pos = r;
      return;
    end
    col_pos = 0;
    r++;
    if (r < fh) begin
      row_pos = r;
      return;
    end
    // frame end: choose between this frame's corner and the previous one
    res.kept = 1'b0;
    if (have_window && top_sum >= thresh_q) begin
      res.x = top_x;
      res.y = top_y;
    end else if (have_prev) begin
      res.x = prev_x;
      res.y = prev_y;
      res.kept = 1'b1;
    end else if (have_window) begin
      res.x = top_x;
      res.y = top_y;
    end else begin
      res.x = '0;
      res.y = '0;
    end
    res.sum = have_window ? top_sum : '0;
    corner_q.push_back(res);
    if (have_window || have_prev) begin
      prev_x = res.x;
      prev_y = res.y;
      have_prev = 1'b1;
    end
    clear_frame();
  endfunction

  task automatic report_mismatch(string what, logic [39:0] got, logic [39:0] want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  // compare result beats first, then advance the prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_w_q = FRAME_W_RST;
      frame_h_q = FRAME_H_RST;
      win_w_q = WIN_W_RST;
      win_h_q = WIN_H_RST;
      scale_xy_q = SCALE_XY_RST;
      scale_z_q = SCALE_Z_RST;
      thresh_q = THRESH_RST;
      foreach (mag_lines[i]) mag_lines[i] = '0;
      clear_frame();
      prev_x = '0;
      prev_y = '0;
      have_prev = 1'b0;
      corner_q.delete();
      fail_count_o = 0;
      frames_done_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (corner_q.size() == 0) begin
          $display("[%0t] mismatch: result beat with no frame outstanding", $time);
          fail_count_o++;
        end else begin
          corner_t want;
          want = corner_q.pop_front();
          if (best_x_i !== want.x) report_mismatch("best_x", best_x_i, want.x);
          if (best_y_i !== want.y) report_mismatch("best_y", best_y_i, want.y);
          if (best_sum_i !== want.sum) report_mismatch("best_sum", best_sum_i, want.sum);
          if (kept_previous_i !== want.kept)
            report_mismatch("kept_previous", kept_previous_i, want.kept);
          frames_done_o++;
        end
      end
      if (cfg_we_i) write_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_i)
        take_pixel(flow_x_i, flow_y_i, flow_z_i, depth_mm_i);
      pending_o = corner_q.size();
    end
  end

endmodule

[tb/tb_max_motion_window_finder_top.sv]
// ---------------------------------------------------------------------------
// tb_max_motion_window_finder_top
// drives pixel frames under many window setups with random idling on both
// channels; the checker predicts every frame-end corner and counts mismatches
// ---------------------------------------------------------------------------
module tb_max_motion_window_finder_top;
  import mmwf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIXEL_TARGET = 1350;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 100;

  logic               clk_i, rst_ni;
  logic               cfg_we_i;
  logic [2:0]         cfg_index_i;
  logic [CFG_DW-1:0]  cfg_data_i;
  logic               in_valid_i, in_stall_o;
  logic signed [15:0] flow_x_i, flow_y_i, flow_z_i;
  logic [15:0]        depth_mm_i;
  logic               out_valid_o, out_stall_i;
  logic [7:0]         best_x_o, best_y_o;
  logic [39:0]        best_sum_o;
  logic               kept_previous_o;

  int fail_count, pending, frames_done;
  int pixels_sent, phases_run;
  int send_idle_pct, recv_idle_pct;
  int hold_left;

  max_motion_window_finder_top dut (.*);

  mmwf_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o),
    .flow_x_i, .flow_y_i, .flow_z_i, .depth_mm_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .best_x_i(best_x_o), .best_y_i(best_y_o), .best_sum_i(best_sum_o),
    .kept_previous_i(kept_previous_o),
    .fail_count_o(fail_count), .pending_o(pending), .frames_done_o(frames_done)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // result side stall, with an optional long hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  task automatic write_cfg(logic [2:0] idx, logic [39:0] v, logic [39:0] keep_mask);
    logic [39:0] data;
    // junk above the register width must be ignored
    data = 40'({$urandom, $urandom});
    data = (data & ~keep_mask) | (v & keep_mask);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic setup_frame(int fw, int fh, int ww, int wh,
                             logic [19:0] sxy, logic [15:0] sz, logic [39:0] thr);
    wait_drained();
    write_cfg(REG_FRAME_W, 40'(fw), 40'h1FF);
    write_cfg(REG_FRAME_H, 40'(fh), 40'h1FF);
    write_cfg(REG_WIN_W, 40'(ww), 40'h1FF);
    write_cfg(REG_WIN_H, 40'(wh), 40'h7F);
    write_cfg(REG_SCALE_XY, 40'(sxy), 40'hFFFFF);
    write_cfg(REG_SCALE_Z, 40'(sz), 40'hFFFF);
    write_cfg(REG_THRESH, thr, 40'hFF_FFFF_FFFF);
    phases_run++;
  endtask

  // one pixel beat; valid stays up across back-to-back beats
  task automatic send_pixel(logic [15:0] fx, logic [15:0] fy, logic [15:0] fz,
                            logic [15:0] dmm);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    flow_x_i <= fx;
    flow_y_i <= fy;
    flow_z_i <= fz;
    depth_mm_i <= dmm;
    do @(posedge clk_i); while (in_stall_o);
    pixels_sent++;
    if (pixels_sent < PIXEL_TARGET / 3) begin
      send_idle_pct = 6;
      recv_idle_pct = 77;
    end else if (pixels_sent < 2 * PIXEL_TARGET / 3) begin
      send_idle_pct = 77;
      recv_idle_pct = 6;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  task automatic end_burst();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] random_flow();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 1200)) - 16'd600;
      1: return 16'($urandom_range(0, 40)) - 16'd20;
      2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      3: return '0;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] random_depth();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return 16'($urandom_range(300, 4000));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random(int n);
    repeat (n) send_pixel(random_flow(), random_flow(), random_flow(), random_depth());
    end_burst();
  endtask

  initial begin
    int fw, fh, ww, wh, frames, extra;
    logic [39:0] thr;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = REG_FRAME_W;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    flow_x_i = '0;
    flow_y_i = '0;
    flow_z_i = '0;
    depth_mm_i = '0;
    pixels_sent = 0;
    phases_run = 0;
    hold_left = 0;
    send_idle_pct = 6;
    recv_idle_pct = 77;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // field extremes in a 4x3 frame, 2x2 windows, threshold zero
    setup_frame(4, 3, 2, 2, 20'd7989, 16'd1024, 40'd0);
    send_pixel(16'h8000, 16'h0000, 16'h0000, 16'd0);
    send_pixel(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
    send_pixel(16'h0000, 16'h8000, 16'h0000, 16'd1);
    send_pixel(16'h0000, 16'h0000, 16'h8000, 16'd1000);
    send_pixel(16'hFFFF, 16'h0001, 16'hFFFF, 16'd0);
    send_pixel(16'h0100, 16'hFF00, 16'h0080, 16'd2500);
    send_pixel(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    send_pixel(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    send_pixel(16'h0000, 16'h0000, 16'h0000, 16'd0);
    send_pixel(16'h8000, 16'h8000, 16'h8000, 16'hFFFF);
    send_pixel(16'h0001, 16'h0000, 16'h0000, 16'd1);
    send_pixel(16'h0000, 16'h0001, 16'h0001, 16'd0);
    end_burst();
    // all-zero frame under maximum threshold: tied sums, previous corner kept
    setup_frame(4, 3, 2, 2, 20'hFFFFF, 16'hFFFF, 40'hFF_FFFF_FFFF);
    repeat (12) send_pixel('0, '0, '0, '0);
    end_burst();
    // window wider than frame: no window fits
    setup_frame(3, 2, 5, 1, 20'd0, 16'd0, 40'd5);
    send_random(6);

    // receiver holds off while 1x1 frames keep coming
    setup_frame(1, 1, 1, 1, 20'd7989, 16'd1024, 40'd1000);
    hold_left = 800;
    send_random(30);

    // register extremes: clamping, full-width line, full-height window
    setup_frame(0, 0, 0, 0, 20'hFFFFF, 16'hFFFF, 40'd0);
    send_random(3);
    setup_frame(511, 1, 511, 127, 20'd1, 16'd1, 40'd1);
    send_random(256);
    setup_frame(256, 1, 256, 1, 20'd7989, 16'd1024, 40'd10000000);
    send_random(256);
    setup_frame(1, 64, 1, 64, 20'd7989, 16'd1024, 40'd10000000);
    send_random(64);
    setup_frame(2, 65, 1, 127, 20'd30000, 16'd4000, 40'd0);
    send_random(130);

    // random small frames, sometimes cut short by the next setup
    while (pixels_sent < PIXEL_TARGET) begin
      fw = $urandom_range(1, 8);
      fh = $urandom_range(1, 6);
      ww = $urandom_range(1, fw + 1);
      wh = $urandom_range(1, fh + 1);
      case ($urandom_range(0, 3))
        0: thr = 40'({$urandom, $urandom});
        1: thr = '0;
        default: thr = 40'($urandom_range(0, 32'h1FFF_FFFF));
      endcase
      setup_frame(fw, fh, ww, wh, 20'($urandom), 16'($urandom), thr);
      frames = $urandom_range(1, 4);
      extra = ($urandom_range(0, 3) == 0) ? $urandom_range(0, fw * fh - 1) : 0;
      send_random(frames * fw * fh + extra);
    end

    wait_drained();
    $display("sent %0d pixels over %0d setups, checked %0d frame results",
             pixels_sent, phases_run, frames_done);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[max_motion_window_finder_top.f]
+incdir+rtl/core
rtl/core/mmwf_pkg.sv
rtl/core/mmwf_sqrt.sv
rtl/core/mmwf_datapath.sv
rtl/core/mmwf_ctrl.sv
rtl/core/max_motion_window_finder_top.sv
tb/mmwf_checker.sv
tb/tb_max_motion_window_finder_top.sv
